>>> rtl/core/ladq_pkg.sv
// Shared types and command/status codes for the linear array deque.
package ladq_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;

    typedef logic [CMD_W-1:0]        cmd_t;
    typedef logic [STATUS_W-1:0]     status_t;
    typedef logic signed [DATA_W-1:0] data_t;

    localparam cmd_t CMD_INS_FRONT = 3'd0;
    localparam cmd_t CMD_INS_REAR  = 3'd1;
    localparam cmd_t CMD_DEL_FRONT = 3'd2;
    localparam cmd_t CMD_DEL_REAR  = 3'd3;
    localparam cmd_t CMD_DISPLAY   = 3'd4;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_OVERFLOW  = 2'd1;
    localparam status_t ST_UNDERFLOW = 2'd2;
    localparam status_t ST_EMPTY     = 2'd3;

endpackage

>>> rtl/core/linear_array_deque.sv
// Linear array deque: a double-ended queue in a fixed array of DEPTH slots.
// The front grows down toward slot 0 and the rear up toward slot DEPTH-1; an
// insert on a side that has reached its end reports overflow even when the
// other side has room. Deletes on an empty queue report underflow, and the
// delete that empties the queue sends both indices back to slot 0. A display
// streams the stored elements front to rear, one transfer per cycle unless
// out_stall holds the output, with last set on the final one; an empty queue
// gives a single empty status. An insert or delete command is accepted and
// accesses the element memory, then its result goes to the output register. A
// display is paced by the single read port of the element memory. Command
// codes 5 to 7 are dropped and give no result. The output register lets a new
// command be accepted while the previous result still waits on out_stall.
module linear_array_deque #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ladq_pkg::cmd_t     cmd,
    input  ladq_pkg::data_t    value,
    output logic               out_valid,
    input  logic               out_stall,
    output ladq_pkg::status_t  status,
    output ladq_pkg::data_t    data,
    output logic               last
);
    import ladq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_PEND = 1'b1;

    logic          state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic          empty_reg, empty_next;
    logic [AW-1:0] walk_reg, walk_next;
    status_t       pend_status_reg, pend_status_next;
    logic          pend_last_reg, pend_last_next;
    logic          pend_ram_reg, pend_ram_next;
    logic          pend_walk_reg, pend_walk_next;
    logic          out_valid_reg, out_valid_next;
    status_t       out_status_reg, out_status_next;
    data_t         out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    data_t         ram_rdata;
    logic          out_free;
    logic [AW-1:0] walk_inc;

    ladq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign walk_inc  = walk_reg + AW'(1);

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        empty_next       = empty_reg;
        walk_next        = walk_reg;
        pend_status_next = pend_status_reg;
        pend_last_next   = pend_last_reg;
        pend_ram_next    = pend_ram_reg;
        pend_walk_next   = pend_walk_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_re           = 1'b0;
        ram_raddr        = '0;

        // Output register drains independently of the command side.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pend_status_next = ST_OK;
                    pend_last_next   = 1'b1;
                    pend_ram_next    = 1'b0;
                    pend_walk_next   = 1'b0;
                    state_next       = S_PEND;
                    case (cmd)
                        CMD_INS_FRONT, CMD_INS_REAR:
                        begin
                            if (empty_reg)
                            begin
                                head_next  = '0;
                                tail_next  = '0;
                                empty_next = 1'b0;
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                            end
                            else if (cmd == CMD_INS_FRONT)
                            begin
                                if (head_reg == '0)
                                begin
                                    pend_status_next = ST_OVERFLOW;
                                end
                                else
                                begin
                                    head_next = head_reg - AW'(1);
                                    ram_we    = 1'b1;
                                    ram_waddr = head_reg - AW'(1);
                                end
                            end
                            else
                            begin
                                if (tail_reg == LAST_SLOT)
                                begin
                                    pend_status_next = ST_OVERFLOW;
                                end
                                else
                                begin
                                    tail_next = tail_reg + AW'(1);
                                    ram_we    = 1'b1;
                                    ram_waddr = tail_reg + AW'(1);
                                end
                            end
                        end
                        CMD_DEL_FRONT, CMD_DEL_REAR:
                        begin
                            if (empty_reg)
                            begin
                                pend_status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                ram_re        = 1'b1;
                                ram_raddr     = (cmd == CMD_DEL_FRONT) ? head_reg : tail_reg;
                                pend_ram_next = 1'b1;
                                if (head_reg == tail_reg)
                                begin
                                    head_next  = '0;
                                    tail_next  = '0;
                                    empty_next = 1'b1;
                                end
                                else if (cmd == CMD_DEL_FRONT)
                                begin
                                    head_next = head_reg + AW'(1);
                                end
                                else
                                begin
                                    tail_next = tail_reg - AW'(1);
                                end
                            end
                        end
                        CMD_DISPLAY:
                        begin
                            if (empty_reg)
                            begin
                                pend_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re         = 1'b1;
                                ram_raddr      = head_reg;
                                walk_next      = head_reg;
                                pend_ram_next  = 1'b1;
                                pend_walk_next = 1'b1;
                                pend_last_next = (head_reg == tail_reg);
                            end
                        end
                        default:
                        begin
                            // Drop unused codes without a result.
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PEND:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_data_next   = pend_ram_reg ? ram_rdata : '0;
                    out_last_next   = pend_last_reg;
                    if (pend_walk_reg && !pend_last_reg)
                    begin
                        // Advance the display to the next slot.
                        walk_next      = walk_inc;
                        ram_re         = 1'b1;
                        ram_raddr      = walk_inc;
                        pend_last_next = (walk_inc == tail_reg);
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg        <= walk_next;
        pend_status_reg <= pend_status_next;
        pend_last_reg   <= pend_last_next;
        pend_ram_reg    <= pend_ram_next;
        pend_walk_reg   <= pend_walk_next;
        out_status_reg  <= out_status_next;
        out_data_reg    <= out_data_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign data      = out_data_reg;
    assign last      = out_last_reg;

endmodule

>>> rtl/core/ladq_ram.sv
// Element store: one write port, one read port with registered read data.
module ladq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  ladq_pkg::data_t  wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output ladq_pkg::data_t  rdata
);
    import ladq_pkg::*;

    data_t mem [DEPTH];
    data_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> tb/sv/ladq_checker.sv
// Checker for the linear array deque: tracks the deque contents and checks every reply.
`timescale 1ns / 100ps

module ladq_checker #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  ladq_pkg::cmd_t     cmd,
    input  ladq_pkg::data_t    value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  ladq_pkg::status_t  status,
    input  ladq_pkg::data_t    data,
    input  logic               last,
    output int                 fail_count,
    output int                 pending,
    output int                 cmd_count,
    output int                 reply_count,
    output int                 overflow_count,
    output int                 underflow_count,
    output int                 empty_count
);

    import ladq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    typedef struct packed {
        status_t status;
        data_t   data;
        logic    last;
    } reply_t;

    // Shadow copy of the deque
    data_t            store [DEPTH];
    logic [IDX_W-1:0] front_idx;
    logic [IDX_W-1:0] rear_idx;
    logic             dq_empty;

    reply_t replies [$];

    int errs;
    int n_cmds;
    int n_replies;
    int n_over;
    int n_under;
    int n_empty;

    initial
    begin
        fail_count      = 0;
        pending         = 0;
        cmd_count       = 0;
        reply_count     = 0;
        overflow_count  = 0;
        underflow_count = 0;
        empty_count     = 0;
        errs            = 0;
        n_cmds          = 0;
        n_replies       = 0;
        n_over          = 0;
        n_under         = 0;
        n_empty         = 0;
        front_idx       = '0;
        rear_idx        = '0;
        dq_empty        = 1'b1;
    end

    task push_reply(input status_t st, input data_t d, input logic fin);
        reply_t r;
        r.status = st;
        r.data   = d;
        r.last   = fin;
        replies.push_back(r);
    endtask

    // Work out the replies for one command and advance the shadow deque.
    task predict_deque(input cmd_t c, input data_t v);
        int   k;
        data_t d;
        case (c)
            CMD_INS_FRONT, CMD_INS_REAR:
            begin
                if (dq_empty)
                begin
                    // an empty deque always restarts at slot 0
                    front_idx = '0;
                    rear_idx  = '0;
                    dq_empty  = 1'b0;
                    store[0]  = v;
                    push_reply(ST_OK, '0, 1'b1);
                end
                else if (c == CMD_INS_FRONT && front_idx == 0)
                    push_reply(ST_OVERFLOW, '0, 1'b1);
                else if (c == CMD_INS_REAR && rear_idx == DEPTH - 1)
                    push_reply(ST_OVERFLOW, '0, 1'b1);
                else if (c == CMD_INS_FRONT)
                begin
                    front_idx        = front_idx - 1'b1;
                    store[front_idx] = v;
                    push_reply(ST_OK, '0, 1'b1);
                end
                else
                begin
                    rear_idx        = rear_idx + 1'b1;
                    store[rear_idx] = v;
                    push_reply(ST_OK, '0, 1'b1);
                end
            end
            CMD_DEL_FRONT, CMD_DEL_REAR:
            begin
                if (dq_empty)
                    push_reply(ST_UNDERFLOW, '0, 1'b1);
                else
                begin
                    d = (c == CMD_DEL_FRONT) ? store[front_idx] : store[rear_idx];
                    if (front_idx == rear_idx)
                    begin
                        dq_empty  = 1'b1;
                        front_idx = '0;
                        rear_idx  = '0;
                    end
                    else if (c == CMD_DEL_FRONT)
                        front_idx = front_idx + 1'b1;
                    else
                        rear_idx = rear_idx - 1'b1;
                    push_reply(ST_OK, d, 1'b1);
                end
            end
            CMD_DISPLAY:
            begin
                if (dq_empty)
                    push_reply(ST_EMPTY, '0, 1'b1);
                else
                    for (k = int'(front_idx); k <= int'(rear_idx); k++)
                        push_reply(ST_OK, store[k], k == int'(rear_idx));
            end
            default:
                ; // drop unused codes
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            front_idx = '0;
            rear_idx  = '0;
            dq_empty  = 1'b1;
            replies.delete();
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (cmd <= CMD_DISPLAY)
                    n_cmds++;
                predict_deque(cmd, value);
            end
            if (out_valid && !out_stall)
            begin
                if (replies.size() == 0)
                begin
                    errs++;
                    $error("unexpected reply: status %0d data %0d last %0b",
                           status, data, last);
                end
                else
                begin
                    want = replies.pop_front();
                    n_replies++;
                    if (status !== want.status)
                    begin
                        errs++;
                        $error("status: expected %0d, actual %0d", want.status, status);
                    end
                    if (data !== want.data)
                    begin
                        errs++;
                        $error("data: expected %0d, actual %0d", want.data, data);
                    end
                    if (last !== want.last)
                    begin
                        errs++;
                        $error("last: expected %0b, actual %0b", want.last, last);
                    end
                    case (want.status)
                        ST_OVERFLOW:  n_over++;
                        ST_UNDERFLOW: n_under++;
                        ST_EMPTY:     n_empty++;
                        default:      ;
                    endcase
                end
            end
            pending         <= replies.size();
            fail_count      <= errs;
            cmd_count       <= n_cmds;
            reply_count     <= n_replies;
            overflow_count  <= n_over;
            underflow_count <= n_under;
            empty_count     <= n_empty;
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// Top of the linear array deque testbench: clock, reset, command stream and verdict.
`timescale 1ns / 100ps

module tb_top;

    import ladq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int PHASE_ITEMS = 75;
    localparam int DRAIN       = 40;
    localparam int LIMIT       = 200000;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    logic    in_stall;
    cmd_t    cmd       = '0;
    data_t   value     = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    status_t status;
    data_t   data;
    logic    last;

    int fail_count;
    int pending;
    int cmd_count;
    int reply_count;
    int overflow_count;
    int underflow_count;
    int empty_count;

    int idle_tab  [4] = '{0, 50, 0, 22};
    int stall_tab [4] = '{0, 0, 50, 22};
    int idle_pct      = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int cycle_count   = 0;

    always #6 clk = ~clk;

    linear_array_deque #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data      (data),
        .last      (last)
    );

    ladq_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .value           (value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .data            (data),
        .last            (last),
        .fail_count      (fail_count),
        .pending         (pending),
        .cmd_count       (cmd_count),
        .reply_count     (reply_count),
        .overflow_count  (overflow_count),
        .underflow_count (underflow_count),
        .empty_count     (empty_count)
    );

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding", cycle_count, pending);
            $display("linear_array_deque verification failed");
            $finish;
        end
    end

    function automatic data_t rand_value();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Hold one command on the port until the block takes it.
    task send_cmd(input cmd_t c, input data_t v);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (c <= CMD_DISPLAY)
            items_sent++;
    endtask

    task send_delete();
        send_cmd($urandom_range(1) ? CMD_DEL_FRONT : CMD_DEL_REAR, rand_value());
    endtask

    // One burst of commands shaped to push the deque to its edges.
    task random_episode(input int kind);
        int n;
        int m;
        int j;
        if (kind < 3)
        begin
            // grow from the rear, often far enough to overflow
            n = $urandom_range(18, 1);
            for (j = 0; j < n; j++)
                send_cmd(CMD_INS_REAR, rand_value());
            send_cmd(CMD_DISPLAY, rand_value());
        end
        else if (kind < 6)
        begin
            // open room at the front, then refill it past slot 0
            n = $urandom_range(10, 2);
            m = $urandom_range(n - 1, 1);
            for (j = 0; j < n; j++)
                send_cmd(CMD_INS_REAR, rand_value());
            for (j = 0; j < m; j++)
                send_cmd(CMD_DEL_FRONT, rand_value());
            for (j = 0; j <= m; j++)
                send_cmd(CMD_INS_FRONT, rand_value());
            send_cmd(CMD_DISPLAY, rand_value());
        end
        else if (kind < 8)
        begin
            n = $urandom_range(18, 1);
            for (j = 0; j < n; j++)
            begin
                send_delete();
                if ($urandom_range(4) == 0)
                    send_cmd(CMD_DISPLAY, rand_value());
            end
        end
        else if (kind == 8)
        begin
            n = $urandom_range(6, 1);
            for (j = 0; j < n; j++)
                send_cmd(cmd_t'($urandom_range(7)), rand_value());
        end
        else
        begin
            send_cmd(CMD_DISPLAY, rand_value());
            send_cmd(cmd_t'($urandom_range(3)), rand_value());
        end
    endtask

    initial
    begin
        int ph;
        int goal;
        int j;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (ph = 0; ph < 4; ph++)
        begin
            idle_pct  = idle_tab[ph];
            stall_pct <= stall_tab[ph];
            if (ph == 0)
            begin
                // empty-queue cases, both edges, inserts into an empty queue
                send_cmd(CMD_DISPLAY, 32'h1234_5678);
                send_cmd(CMD_DEL_FRONT, '1);
                send_cmd(CMD_DEL_REAR, '0);
                send_cmd(CMD_INS_FRONT, 32'h8000_0000);
                send_cmd(CMD_INS_FRONT, 32'h7fff_ffff);
                send_cmd(CMD_INS_REAR, 32'h7fff_ffff);
                send_cmd(CMD_INS_REAR, '0);
                send_cmd(CMD_INS_REAR, '1);
                send_cmd(CMD_DISPLAY, '0);
                send_cmd(CMD_DEL_FRONT, '0);
                send_cmd(CMD_INS_FRONT, 32'h5555_5555);
                send_cmd(CMD_DEL_REAR, '0);
                send_cmd(CMD_DEL_REAR, '0);
                send_cmd(CMD_DEL_FRONT, '0);
                send_cmd(CMD_DEL_FRONT, '0);
                send_cmd(CMD_DISPLAY, '1);
                send_cmd(CMD_INS_REAR, 32'haaaa_aaaa);
                send_cmd(cmd_t'(5), '1);
                send_cmd(cmd_t'(6), 32'h8000_0000);
                send_cmd(cmd_t'(7), 32'h7fff_ffff);
                send_cmd(CMD_DEL_REAR, '0);
                send_cmd(CMD_DISPLAY, '0);
                // fill the whole array from the rear and run into its end
                for (j = 0; j < DEPTH + 1; j++)
                    send_cmd(CMD_INS_REAR, rand_value());
                send_cmd(CMD_DISPLAY, '0);
            end
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
                random_episode($urandom_range(9));
        end

        in_valid  <= 1'b0;
        stall_pct <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Run covered %0d commands and %0d replies over four handshake phases.",
                 cmd_count, reply_count);
        $display("Replies seen: %0d overflow, %0d underflow, %0d empty display.",
                 overflow_count, underflow_count, empty_count);
        if (fail_count == 0 && pending == 0)
            $display("linear_array_deque verification clean");
        else
            $display("linear_array_deque verification failed");
        $finish;
    end

endmodule
